### hdl/skrc_pkg.sv
// shared types and constants of the sorted key range counter
package skrc_pkg;

    localparam int KEY_W       = 30;
    localparam int HIT_W       = 11;
    localparam int STATUS_W    = 2;
    localparam int S_TDATA_W   = 96;
    localparam int M_TDATA_W   = 16;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK   = 2'd0,
        STATUS_DUP  = 2'd1,
        STATUS_FULL = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_DUP_RD,
        ST_DUP_CMP,
        ST_SHIFT_PRIME,
        ST_SHIFT,
        ST_PUT,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        PH_INSERT,
        PH_UPPER,
        PH_LOWER
    } phase_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_LOAD_LOW,
        OP_SRCH_RD,
        OP_SRCH_CMP,
        OP_DUP_RD,
        OP_SHIFT_PRIME,
        OP_SHIFT_STEP,
        OP_PUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        logic    out_load;
        status_t res_status;
    } dp_cmd_t;

    typedef struct packed {
        logic search_busy;
        logic slot_lt_count;
        logic key_match;
        logic full;
        logic shift_last;
        logic out_free;
    } dp_stat_t;

endpackage

### hdl/sorted_key_range_counter_top.sv
// sorted key range counter: top level
//
// holds a sorted set of distinct keys in a single ram. every input item on the
// s_axis channel gives exactly one result item on the m_axis channel, in order.
// s_axis_tuser = 0 inserts the key in tdata bits 29:0; a key already present is
// reported as duplicate, an insert into a full table is refused and reported.
// s_axis_tuser = 1 counts stored keys in the inclusive range given by tdata
// bits 59:30 (low) and 89:60 (high); an empty range counts zero.
// work per item, set by the single ram read port and the sequencer:
//   query: 2 binary searches, each probe a ram read then a compare step
//   insert: one search, a duplicate probe when the slot holds a key, then one
//   key moved up per cycle for every entry above the slot, then the new key is written
// one item is in work at a time; s_axis_tready is high only between items.
// results sit in an output register, so the next item is taken while a result
// waits; a stalled receiver holds the block only when a second result is ready.
// reset empties the table at once (no clearing pass) and drops any result.
module sorted_key_range_counter_top #(
    parameter int CAPACITY = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // position[29:0], range_low[59:30], range_high[89:60], zero pad
    input  logic [skrc_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // mode[0]
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // status[1:0], hit_count[12:2], zero pad
    output logic [skrc_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

    skrc_pkg::dp_cmd_t  cmd;
    skrc_pkg::dp_stat_t stat;

    skrc_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    skrc_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata),
        .stat          (stat)
    );

endmodule

### hdl/skrc_ram.sv
// generic simple dual-port ram with registered read
module skrc_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### hdl/skrc_datapath.sv
// key store, search registers, shift pointer and output register
module skrc_datapath #(
    parameter int CAPACITY = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  skrc_pkg::dp_cmd_t               cmd,
    input  logic [skrc_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    input  logic                            s_axis_tuser,
    input  logic                            m_axis_tready,
    output logic                            m_axis_tvalid,
    output logic [skrc_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    output skrc_pkg::dp_stat_t              stat
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int KW = skrc_pkg::KEY_W;
    localparam int HW = skrc_pkg::HIT_W;

    logic [KW-1:0] value_reg, low_reg;
    logic          incl_reg, mode_reg;
    logic [CW-1:0] lo_reg, hi_reg, upper_reg, count_reg, wr_ptr_reg;
    logic          m_valid_reg;
    logic [skrc_pkg::M_TDATA_W-1:0] m_data_reg;

    logic [CW:0]   mid_sum;
    logic [CW-1:0] mid, count_m1, wr_ptr_m2, slot_p1, diff;
    logic [CW+HW-1:0] diff_ext;
    logic [HW-1:0] hit;
    logic          probe_lt;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [KW-1:0] ram_wdata, ram_rdata;

    logic [KW-1:0] in_position, in_low, in_high;

    assign in_position = s_axis_tdata[KW-1:0];
    assign in_low      = s_axis_tdata[2*KW-1:KW];
    assign in_high     = s_axis_tdata[3*KW-1:2*KW];

    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid       = mid_sum[CW:1];
    assign count_m1  = count_reg - CW'(1);
    assign wr_ptr_m2 = wr_ptr_reg - CW'(2);
    assign slot_p1   = lo_reg + CW'(1);
    assign probe_lt  = incl_reg ? (ram_rdata <= value_reg) : (ram_rdata < value_reg);

    assign diff     = (upper_reg > lo_reg) ? (upper_reg - lo_reg) : '0;
    assign diff_ext = {{HW{1'b0}}, diff};
    assign hit      = mode_reg ? diff_ext[HW-1:0] : '0;

    assign stat.search_busy   = lo_reg < hi_reg;
    assign stat.slot_lt_count = lo_reg < count_reg;
    assign stat.key_match     = ram_rdata == value_reg;
    assign stat.full          = count_reg == CW'(CAPACITY);
    assign stat.shift_last    = wr_ptr_reg == slot_p1;
    assign stat.out_free      = !m_valid_reg || m_axis_tready;

    always_comb begin
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = wr_ptr_reg[AW-1:0];
        ram_raddr = mid[AW-1:0];
        ram_wdata = ram_rdata;
        unique case (cmd.op)
            skrc_pkg::OP_SRCH_RD: begin
                ram_re    = 1'b1;
                ram_raddr = mid[AW-1:0];
            end
            skrc_pkg::OP_DUP_RD: begin
                ram_re    = 1'b1;
                ram_raddr = lo_reg[AW-1:0];
            end
            skrc_pkg::OP_SHIFT_PRIME: begin
                ram_re    = 1'b1;
                ram_raddr = count_m1[AW-1:0];
            end
            skrc_pkg::OP_SHIFT_STEP: begin
                ram_we    = 1'b1;
                ram_waddr = wr_ptr_reg[AW-1:0];
                ram_wdata = ram_rdata;
                ram_re    = !stat.shift_last;
                ram_raddr = wr_ptr_m2[AW-1:0];
            end
            skrc_pkg::OP_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = lo_reg[AW-1:0];
                ram_wdata = value_reg;
            end
            default: begin
            end
        endcase
    end

    skrc_ram #(
        .WIDTH (KW),
        .DEPTH (CAPACITY)
    ) u_keys (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            skrc_pkg::OP_LOAD: begin
                mode_reg  <= s_axis_tuser;
                incl_reg  <= s_axis_tuser;
                value_reg <= s_axis_tuser ? in_high : in_position;
                low_reg   <= in_low;
                lo_reg    <= '0;
                hi_reg    <= count_reg;
            end
            skrc_pkg::OP_LOAD_LOW: begin
                incl_reg  <= 1'b0;
                value_reg <= low_reg;
                upper_reg <= lo_reg;
                lo_reg    <= '0;
                hi_reg    <= count_reg;
            end
            skrc_pkg::OP_SRCH_CMP: begin
                if (probe_lt) begin
                    lo_reg <= mid + CW'(1);
                end else begin
                    hi_reg <= mid;
                end
            end
            skrc_pkg::OP_SHIFT_PRIME: begin
                wr_ptr_reg <= count_reg;
            end
            skrc_pkg::OP_SHIFT_STEP: begin
                wr_ptr_reg <= wr_ptr_reg - CW'(1);
            end
            default: begin
            end
        endcase
        if (cmd.out_load) begin
            m_data_reg <= skrc_pkg::M_TDATA_W'({hit, cmd.res_status});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.op == skrc_pkg::OP_PUT) begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

### hdl/skrc_ctrl.sv
// sequencer for insert and range count operations
module skrc_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_axis_tvalid,
    input  logic               s_axis_tuser,
    output logic               s_axis_tready,
    input  skrc_pkg::dp_stat_t stat,
    output skrc_pkg::dp_cmd_t  cmd
);

    skrc_pkg::state_t  state_reg, state_next;
    skrc_pkg::phase_t  phase_reg, phase_next;
    skrc_pkg::status_t status_reg, status_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= skrc_pkg::ST_IDLE;
            phase_reg  <= skrc_pkg::PH_INSERT;
            status_reg <= skrc_pkg::STATUS_OK;
        end else begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            status_reg <= status_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        status_next = status_reg;
        unique case (state_reg)
            skrc_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    state_next  = skrc_pkg::ST_SRCH_RD;
                    phase_next  = s_axis_tuser ? skrc_pkg::PH_UPPER : skrc_pkg::PH_INSERT;
                    status_next = skrc_pkg::STATUS_OK;
                end
            end
            skrc_pkg::ST_SRCH_RD: begin
                if (stat.search_busy) begin
                    state_next = skrc_pkg::ST_SRCH_CMP;
                end else begin
                    unique case (phase_reg)
                        skrc_pkg::PH_INSERT: state_next = skrc_pkg::ST_DUP_RD;
                        skrc_pkg::PH_UPPER:  phase_next = skrc_pkg::PH_LOWER;
                        skrc_pkg::PH_LOWER:  state_next = skrc_pkg::ST_FINISH;
                        default:             state_next = skrc_pkg::ST_FINISH;
                    endcase
                end
            end
            skrc_pkg::ST_SRCH_CMP: begin
                state_next = skrc_pkg::ST_SRCH_RD;
            end
            skrc_pkg::ST_DUP_RD: begin
                priority if (stat.slot_lt_count) begin
                    state_next = skrc_pkg::ST_DUP_CMP;
                end else if (stat.full) begin
                    status_next = skrc_pkg::STATUS_FULL;
                    state_next  = skrc_pkg::ST_FINISH;
                end else begin
                    state_next = skrc_pkg::ST_PUT;
                end
            end
            skrc_pkg::ST_DUP_CMP: begin
                priority if (stat.key_match) begin
                    status_next = skrc_pkg::STATUS_DUP;
                    state_next  = skrc_pkg::ST_FINISH;
                end else if (stat.full) begin
                    status_next = skrc_pkg::STATUS_FULL;
                    state_next  = skrc_pkg::ST_FINISH;
                end else begin
                    state_next = skrc_pkg::ST_SHIFT_PRIME;
                end
            end
            skrc_pkg::ST_SHIFT_PRIME: begin
                state_next = skrc_pkg::ST_SHIFT;
            end
            skrc_pkg::ST_SHIFT: begin
                if (stat.shift_last) begin
                    state_next = skrc_pkg::ST_PUT;
                end
            end
            skrc_pkg::ST_PUT: begin
                state_next = skrc_pkg::ST_FINISH;
            end
            skrc_pkg::ST_FINISH: begin
                if (stat.out_free) begin
                    state_next = skrc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = skrc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_axis_tready  = 1'b0;
        cmd.op         = skrc_pkg::OP_NONE;
        cmd.out_load   = 1'b0;
        cmd.res_status = status_reg;
        unique case (state_reg)
            skrc_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    cmd.op = skrc_pkg::OP_LOAD;
                end
            end
            skrc_pkg::ST_SRCH_RD: begin
                if (stat.search_busy) begin
                    cmd.op = skrc_pkg::OP_SRCH_RD;
                end else if (phase_reg == skrc_pkg::PH_UPPER) begin
                    cmd.op = skrc_pkg::OP_LOAD_LOW;
                end
            end
            skrc_pkg::ST_SRCH_CMP: begin
                cmd.op = skrc_pkg::OP_SRCH_CMP;
            end
            skrc_pkg::ST_DUP_RD: begin
                if (stat.slot_lt_count) begin
                    cmd.op = skrc_pkg::OP_DUP_RD;
                end
            end
            skrc_pkg::ST_DUP_CMP: begin
            end
            skrc_pkg::ST_SHIFT_PRIME: begin
                cmd.op = skrc_pkg::OP_SHIFT_PRIME;
            end
            skrc_pkg::ST_SHIFT: begin
                cmd.op = skrc_pkg::OP_SHIFT_STEP;
            end
            skrc_pkg::ST_PUT: begin
                cmd.op = skrc_pkg::OP_PUT;
            end
            skrc_pkg::ST_FINISH: begin
                cmd.out_load = stat.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

### hdl/skrc_checker.sv
// port-level checks of the sorted key range counter and their bind
module skrc_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [skrc_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result item dropped or changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> s_axis_tready && !m_axis_tvalid)
        else $error("block not idle after reset");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[1:0] != skrc_pkg::STATUS_W'(3))
        else $error("undefined status code");

    a_insert_no_hits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[1:0] != skrc_pkg::STATUS_OK
            |-> m_axis_tdata[12:2] == '0)
        else $error("refused or duplicate insert carries a hit count");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item taken while previous item still in work");

endmodule

bind sorted_key_range_counter_top skrc_checker u_skrc_checker (.*);

### tb/sv/tb_sorted_key_range_counter_top.sv
// self-checking testbench of the sorted key range counter: inserts and range counts vs a key set
module tb_sorted_key_range_counter_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEY_W = skrc_pkg::KEY_W;
    localparam int HIT_W = skrc_pkg::HIT_W;
    localparam int TABLE_DEPTH = 1024;
    localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};
    localparam logic [KEY_W-1:0] POS_LIMIT = 30'd1000000000;
    localparam logic [KEY_W-1:0] FILL_BASE = 30'h3FFF0000;

    typedef enum logic {
        MODE_INSERT = 1'b0,
        MODE_QUERY  = 1'b1
    } item_mode_t;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } rx_pattern_t;

    typedef struct {
        skrc_pkg::status_t status;
        logic [HIT_W-1:0]  hits;
    } key_result_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [skrc_pkg::S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                            s_axis_tuser = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [skrc_pkg::M_TDATA_W-1:0]  m_axis_tdata;

    // shadow key set
    logic [KEY_W-1:0] key_store [TABLE_DEPTH];
    int               key_total = 0;

    key_result_t pending_results [$];
    int          errors = 0;
    int          items_sent = 0;
    int          results_checked = 0;
    int          dup_seen = 0;
    int          full_seen = 0;
    int          queries_sent = 0;
    int          burst_left = 1;

    rx_pattern_t rx_pattern = RX_OPEN;
    int          rx_left = 0;
    int          rx_tick = 0;

    sorted_key_range_counter_top #(
        .CAPACITY(TABLE_DEPTH)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic int keys_below(input logic [KEY_W-1:0] v);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = key_total;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (key_store[mid] < v) lo = mid + 1;
            else hi = mid;
        end
        return lo;
    endfunction

    function automatic int keys_up_to(input logic [KEY_W-1:0] v);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = key_total;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (key_store[mid] <= v) lo = mid + 1;
            else hi = mid;
        end
        return lo;
    endfunction

    function automatic key_result_t apply_to_key_set(input item_mode_t mode,
                                                     input logic [KEY_W-1:0] pos,
                                                     input logic [KEY_W-1:0] lo,
                                                     input logic [KEY_W-1:0] hi);
        key_result_t r;
        int slot;
        int upper;
        int lower;
        r.status = skrc_pkg::STATUS_OK;
        r.hits = '0;
        if (mode == MODE_INSERT) begin
            slot = keys_below(pos);
            if (slot < key_total && key_store[slot] == pos) begin
                r.status = skrc_pkg::STATUS_DUP;
                dup_seen++;
            end else if (key_total >= TABLE_DEPTH) begin
                r.status = skrc_pkg::STATUS_FULL;
                full_seen++;
            end else begin
                for (int i = key_total; i > slot; i--) key_store[i] = key_store[i-1];
                key_store[slot] = pos;
                key_total++;
            end
        end else begin
            upper = keys_up_to(hi);
            lower = keys_below(lo);
            r.hits = (upper > lower) ? HIT_W'(upper - lower) : '0;
            queries_sent++;
        end
        return r;
    endfunction

    function automatic logic [KEY_W-1:0] rnd_key();
        return KEY_W'($urandom());
    endfunction

    function automatic logic [KEY_W-1:0] stored_key();
        if (key_total == 0) return rnd_key();
        return key_store[$urandom_range(0, key_total - 1)];
    endfunction

    task automatic send_item(input item_mode_t mode, input logic [KEY_W-1:0] pos,
                             input logic [KEY_W-1:0] lo, input logic [KEY_W-1:0] hi);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {6'd0, hi, lo, pos};
        @(negedge aclk);
        while (!s_axis_tready) @(negedge aclk);
        @(posedge aclk);
        pending_results.push_back(apply_to_key_set(mode, pos, lo, hi));
        items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 6);
        end
    endtask

    task automatic insert_key(input logic [KEY_W-1:0] pos);
        send_item(MODE_INSERT, pos, rnd_key(), rnd_key());
    endtask

    task automatic count_range(input logic [KEY_W-1:0] lo, input logic [KEY_W-1:0] hi);
        send_item(MODE_QUERY, rnd_key(), lo, hi);
    endtask

    task automatic test_directed_inserts();
        count_range('0, KEY_MAX);
        insert_key(30'd5);
        insert_key('0);
        insert_key(KEY_MAX);
        insert_key(POS_LIMIT);
        insert_key(POS_LIMIT + 30'd1);
        insert_key(30'd5);
        insert_key(KEY_MAX);
        insert_key(30'd3);
        insert_key('0);
    endtask

    task automatic test_directed_queries();
        count_range('0, KEY_MAX);
        count_range(30'd5, 30'd5);
        count_range(30'd6, 30'd6);
        count_range(30'd6, 30'd4);
        count_range(KEY_MAX, '0);
        count_range('0, '0);
        count_range(KEY_MAX, KEY_MAX);
        count_range(POS_LIMIT, POS_LIMIT + 30'd1);
        count_range(30'd1, POS_LIMIT);
        count_range(30'd4, 30'd4);
        count_range(30'd3, 30'd5);
        count_range(POS_LIMIT + 30'd2, KEY_MAX - 30'd1);
    endtask

    task automatic test_random_mix(input int n_items);
        logic [KEY_W-1:0] a;
        logic [KEY_W-1:0] b;
        int pick;
        for (int n = 0; n < n_items; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                if (pick < 22) insert_key(KEY_W'($urandom_range(0, 511)));
                else if (pick < 33) insert_key(stored_key());
                else insert_key(rnd_key());
            end else begin
                pick = $urandom_range(0, 9);
                if (pick < 3) begin
                    count_range(rnd_key(), rnd_key());
                end else if (pick < 6) begin
                    a = stored_key();
                    b = stored_key();
                    if (a > b) begin
                        a = b ^ a;
                        b = b ^ a;
                        a = b ^ a;
                    end
                    if ($urandom_range(0, 1)) a = a + 30'd1;
                    if ($urandom_range(0, 1)) b = b - 30'd1;
                    count_range(a, b);
                end else if (pick < 8) begin
                    a = KEY_W'($urandom_range(0, 511));
                    count_range(a, a + KEY_W'($urandom_range(0, 200)));
                end else if (pick < 9) begin
                    a = rnd_key() | 30'd1;
                    count_range(a, a - KEY_W'($urandom_range(1, 1000)));
                end else begin
                    a = stored_key();
                    count_range(a, a);
                end
            end
        end
    endtask

    task automatic test_full_table();
        logic [KEY_W-1:0] k;
        int slot;
        k = FILL_BASE;
        // ascending keys near the top keep the shifts short
        while (key_total < TABLE_DEPTH) begin
            slot = keys_below(k);
            if (!(slot < key_total && key_store[slot] == k)) insert_key(k);
            k = k + 30'd1;
        end
        count_range('0, KEY_MAX);
        insert_key(k);
        insert_key(stored_key());
        insert_key('0);
        insert_key(KEY_MAX);
        count_range(KEY_MAX, '0);
        count_range(FILL_BASE, KEY_MAX);
        for (int n = 0; n < 20; n++) begin
            if ($urandom_range(0, 1)) insert_key($urandom_range(0, 1) ? stored_key() : rnd_key());
            else count_range(rnd_key(), rnd_key());
        end
        count_range('0, KEY_MAX);
    endtask

    always @(posedge aclk) begin
        rx_tick <= rx_tick + 1;
        if (rx_left == 0) begin
            rx_pattern <= rx_pattern_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(16, 160);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_pattern)
            RX_OPEN: m_axis_tready <= 1'b1;
            RX_COIN: m_axis_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_axis_tready <= ($urandom_range(0, 7) == 0);
            default: m_axis_tready <= rx_tick[2] & ~rx_tick[0];
        endcase
    end

    always @(negedge aclk) begin : result_check
        key_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with none expected, actual tdata %h", $time, m_axis_tdata);
                errors++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (m_axis_tdata[1:0] !== want.status) begin
                    $display("%0t: status mismatch expected %0d actual %0d",
                             $time, want.status, m_axis_tdata[1:0]);
                    errors++;
                end
                if (m_axis_tdata[12:2] !== want.hits) begin
                    $display("%0t: hit_count mismatch expected %0d actual %0d",
                             $time, want.hits, m_axis_tdata[12:2]);
                    errors++;
                end
            end
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_inserts();
        test_directed_queries();
        test_random_mix(400);
        test_full_table();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (TABLE_DEPTH + 64) @(posedge aclk);
        $display("%0d items sent (%0d range counts), %0d results checked, %0d keys stored",
                 items_sent, queries_sent, results_checked, key_total);
        $display("%0d duplicate inserts and %0d refused inserts into a full table",
                 dup_seen, full_seen);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/skrc_pkg.sv
hdl/skrc_ram.sv
hdl/skrc_datapath.sv
hdl/skrc_ctrl.sv
hdl/sorted_key_range_counter_top.sv
hdl/skrc_checker.sv
tb/sv/tb_sorted_key_range_counter_top.sv
